@@ src/nrt_pkg.sv @@
// Package for the NACK retry table: shared entry and cell control types,
// operation, result kind and status codes, register indexes and the scan state.
// No dependencies; used by nrt_cell and nack_retry_table.
`default_nettype none

package nrt_pkg;

    localparam int PKT_W   = 64;
    localparam int CNT_W   = 16;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [OP_W-1:0] OP_REQUEST  = 2'd0;
    localparam logic [OP_W-1:0] OP_RECEIVED = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RECEIVED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NACK     = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STAT_W-1:0] STAT_PENDING     = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL        = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_PENDING = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_READY  = 2'd1;

    typedef struct packed {
        logic             valid;
        logic [PKT_W-1:0] packet;
        logic [CNT_W-1:0] retries;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

`default_nettype wire

@@ src/nrt_cell.sv @@
// One slot of the NACK retry table: holds an entry, matches it against a
// packet number and takes its neighbor's entry when the row rotates.
// Depends on nrt_pkg.
`default_nettype none

module nrt_cell (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire nrt_pkg::t_cell_ctl    i_ctl,
    input  wire nrt_pkg::t_entry       i_shift_in,
    input  wire [nrt_pkg::PKT_W-1:0]   i_cmp_num,
    output nrt_pkg::t_entry            o_entry,
    output logic                       o_match
);

    logic                      r_valid;
    logic [nrt_pkg::PKT_W-1:0] r_packet;
    logic [nrt_pkg::CNT_W-1:0] r_retries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_shift_in.valid;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_packet  <= i_shift_in.packet;
            r_retries <= i_shift_in.retries;
        end else if (i_ctl.load) begin
            r_packet  <= i_cmp_num;
            r_retries <= '0;
        end
    end

    assign o_entry.valid   = r_valid;
    assign o_entry.packet  = r_packet;
    assign o_entry.retries = r_retries;
    assign o_match         = r_valid && (r_packet == i_cmp_num);

endmodule

`default_nettype wire

@@ src/nack_retry_table.sv @@
// Top level of the NACK retry table: a row of slot cells, the tick scan
// controller, the configuration registers and the result register.
// Depends on nrt_pkg and nrt_cell.
`default_nettype none

// A request or received item needs no scan: every slot compares its number
// in parallel, and the single result appears on the strobe in the cycle after
// acceptance, with busy staying low. A tick (with link_ready set and at least
// one entry stored) rotates the whole row of TABLE_DEPTH cells once through
// the slot-0 end, one slot per cycle, with busy high for the whole rotation;
// one NACK result per stored entry comes out in ascending slot order, each in
// the cycle after its slot reaches the head of the row, so the last one (flagged)
// can appear in the first cycle after busy falls. Results are shown for
// exactly one cycle each and cannot be held off by the receiver. Configuration
// writes are always ready and take effect at once.
module nack_retry_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire [nrt_pkg::OP_W-1:0]         i_op,
    input  wire [nrt_pkg::PKT_W-1:0]        i_packet_number,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [nrt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [nrt_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    output logic                            o_valid,
    output logic [nrt_pkg::KIND_W-1:0]      o_kind,
    output logic [nrt_pkg::STAT_W-1:0]      o_status,
    output logic [nrt_pkg::PKT_W-1:0]       o_nack_number,
    output logic [nrt_pkg::CNT_W-1:0]       o_retries_done,
    output logic                            o_gave_up,
    output logic                            o_last
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    nrt_pkg::t_entry    w_entry [TABLE_DEPTH];
    nrt_pkg::t_cell_ctl w_ctl   [TABLE_DEPTH];
    nrt_pkg::t_entry    w_head_next;

    logic [TABLE_DEPTH-1:0] w_valid;
    logic [TABLE_DEPTH-1:0] w_match;
    logic [TABLE_DEPTH-1:0] w_free;
    logic [TABLE_DEPTH-1:0] w_first_free;
    logic [TABLE_DEPTH-1:0] w_load;
    logic [TABLE_DEPTH-1:0] w_clear;

    nrt_pkg::t_state r_state, n_state;

    logic [nrt_pkg::CNT_W-1:0] r_retry_limit;
    logic                      r_link_ready;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_remain, n_remain;
    logic [CW-1:0]             r_idx, n_idx;

    logic r_out_valid, n_out_valid;
    logic [nrt_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [nrt_pkg::STAT_W-1:0] r_status, n_status;
    logic [nrt_pkg::PKT_W-1:0]  r_number, n_number;
    logic [nrt_pkg::CNT_W-1:0]  r_tries, n_tries;
    logic r_gave, n_gave;
    logic r_last, n_last;

    logic w_accept, w_req, w_rcv, w_tick_go, w_hit, w_full;
    logic w_scanning, w_scan_end, w_give;

    // Row of cells. The last cell takes the updated head entry, so a full
    // rotation puts every entry that did not give up back in its own slot.
    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            nrt_pkg::t_entry w_shift_in;
            if (g == TABLE_DEPTH - 1) begin : g_tail
                assign w_shift_in = w_head_next;
            end else begin : g_body
                assign w_shift_in = w_entry[g+1];
            end

            assign w_ctl[g].shift = w_scanning;
            assign w_ctl[g].load  = w_load[g];
            assign w_ctl[g].clear = w_clear[g];

            nrt_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[g]),
                .i_shift_in (w_shift_in),
                .i_cmp_num  (i_packet_number),
                .o_entry    (w_entry[g]),
                .o_match    (w_match[g])
            );

            assign w_valid[g] = w_entry[g].valid;
        end
    endgenerate

    assign w_free       = ~w_valid;
    assign w_first_free = w_free & (~w_free + {{(TABLE_DEPTH-1){1'b0}}, 1'b1});
    assign w_hit        = |w_match;
    assign w_full       = (w_free == '0);

    assign w_accept  = start && !busy;
    assign w_req     = w_accept && (i_op == nrt_pkg::OP_REQUEST);
    assign w_rcv     = w_accept && (i_op == nrt_pkg::OP_RECEIVED);
    assign w_tick_go = w_accept && (i_op == nrt_pkg::OP_TICK) && r_link_ready
                       && (r_count != '0);

    assign w_load  = (w_req && !w_hit) ? w_first_free : '0;
    assign w_clear = w_rcv ? w_match : '0;

    // Head of the row during a scan: an entry at or past its limit drops out.
    assign w_give              = w_entry[0].retries >= r_retry_limit;
    assign w_head_next.valid   = w_entry[0].valid && !w_give;
    assign w_head_next.packet  = w_entry[0].packet;
    assign w_head_next.retries = w_entry[0].retries + 1'b1;

    assign w_scan_end = (r_idx == CW'(TABLE_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nrt_pkg::ST_IDLE: begin
                if (w_tick_go) begin
                    n_state = nrt_pkg::ST_SCAN;
                end
            end
            nrt_pkg::ST_SCAN: begin
                if (w_scan_end) begin
                    n_state = nrt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = nrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        unique case (r_state)
            nrt_pkg::ST_SCAN: begin
                busy       = 1'b1;
                w_scanning = 1'b1;
            end
            default: begin
                busy       = 1'b0;
                w_scanning = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_remain = r_remain;
        n_idx    = r_idx;
        if (w_scanning) begin
            n_idx = r_idx + 1'b1;
            if (w_entry[0].valid) begin
                n_remain = r_remain - 1'b1;
                if (w_give) begin
                    n_count = r_count - 1'b1;
                end
            end
        end else if (w_tick_go) begin
            n_idx    = '0;
            n_remain = r_count;
        end else if (w_req && !w_hit && !w_full) begin
            n_count = r_count + 1'b1;
        end else if (w_rcv && w_hit) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_out_valid = 1'b0;
        n_kind      = nrt_pkg::KIND_NACK;
        n_status    = nrt_pkg::STAT_OK;
        n_number    = w_entry[0].packet;
        n_tries     = w_entry[0].retries;
        n_gave      = w_give;
        n_last      = (r_remain == CW'(1));
        priority if (w_scanning) begin
            n_out_valid = w_entry[0].valid;
        end else if (w_req) begin
            n_out_valid = 1'b1;
            n_kind      = nrt_pkg::KIND_REQUEST;
            n_number    = i_packet_number;
            n_tries     = '0;
            n_gave      = 1'b0;
            n_last      = 1'b1;
            if (w_hit) begin
                n_status = nrt_pkg::STAT_PENDING;
            end else if (w_full) begin
                n_status = nrt_pkg::STAT_FULL;
            end
        end else if (w_rcv) begin
            n_out_valid = 1'b1;
            n_kind      = nrt_pkg::KIND_RECEIVED;
            n_number    = i_packet_number;
            n_tries     = '0;
            n_gave      = 1'b0;
            n_last      = 1'b1;
            n_status    = w_hit ? nrt_pkg::STAT_OK : nrt_pkg::STAT_NOT_PENDING;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= nrt_pkg::ST_IDLE;
            r_count       <= '0;
            r_remain      <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
            r_retry_limit <= nrt_pkg::CNT_W'(3);
            r_link_ready  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_remain    <= n_remain;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    nrt_pkg::REG_RETRY_LIMIT: r_retry_limit <= i_cfg_data;
                    nrt_pkg::REG_LINK_READY:  r_link_ready  <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_status <= n_status;
        r_number <= n_number;
        r_tries  <= n_tries;
        r_gave   <= n_gave;
        r_last   <= n_last;
    end

    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_out_valid;
    assign o_kind         = r_kind;
    assign o_status       = r_status;
    assign o_nack_number  = r_number;
    assign o_retries_done = r_tries;
    assign o_gave_up      = r_gave;
    assign o_last         = r_last;

endmodule

`default_nettype wire
